/* sv/bae_pkg.sv */
package bae_pkg;

	// Width of one output word and of the bounds.
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned BOUND_W = 32;

	// Interval bounds after reset and after a flush.
	localparam logic [BOUND_W-1:0] BOUND_INIT_LOW  = 32'h0000_0000;
	localparam logic [BOUND_W-1:0] BOUND_INIT_HIGH = 32'hFFFF_FFFF;

	// Fill pattern shifted into the bottom of the high bound.
	localparam logic [BYTE_W-1:0] HIGH_FILL = 8'hFF;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;  // latch the bit and register span times probability
		logic update;   // narrow the interval with the registered product
		logic emit;     // load the top byte of low into the output stage and shift
		logic last;     // the emitted word is the final one of this input word
		logic restore;  // return the bounds to their initial values
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic slot_free;   // output stage can take a word this cycle
		logic upd_match;   // updated bounds agree in their top byte
		logic match_next;  // after one shift the bounds still agree in their top byte
	} status_t;

endpackage

/* sv/bae_ctrl.sv */
module bae_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              req_type,
	input  bae_pkg::status_t  status,
	output bae_pkg::cmd_t     cmd
);
	import bae_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_UPD,
		S_EMIT,
		S_FLUSH
	} state_t;

	state_t     state_q;
	logic [1:0] cnt_q;
	logic       accept;
	logic       cnt_full;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign cnt_full = (cnt_q == 2'd3);

	// Command decode from the current state and the datapath status.
	always_comb begin
		cmd         = '0;
		cmd.capture = accept && !req_type;
		cmd.update  = (state_q == S_UPD);
		cmd.emit    = ((state_q == S_EMIT) || (state_q == S_FLUSH)) && status.slot_free;
		if (state_q == S_EMIT) begin
			cmd.last = cnt_full || !status.match_next;
		end else begin
			cmd.last = cnt_full;
		end
		cmd.restore = (state_q == S_FLUSH) && cmd.emit && cnt_full;
	end

	// State and byte counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					cnt_q <= '0;
					if (accept) begin
						state_q <= req_type ? S_FLUSH : S_UPD;
					end
				end
				S_UPD: begin
					state_q <= status.upd_match ? S_EMIT : S_IDLE;
				end
				S_EMIT, S_FLUSH: begin
					if (cmd.emit) begin
						if (cmd.last) begin
							state_q <= S_IDLE;
							cnt_q   <= '0;
						end else begin
							cnt_q <= cnt_q + 2'd1;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
					cnt_q   <= '0;
				end
			endcase
		end
	end

	// The counter only runs while words are being emitted.
	a_idle_cnt_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (cnt_q == 2'd0))
		else $error("byte counter not clear while idle");

	// A word is only loaded when the output stage has room.
	a_emit_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> status.slot_free)
		else $error("emit issued while output stage is full");

	// A flush always ends on its fourth word.
	a_flush_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FLUSH && cmd.emit && cmd.last) |-> cnt_full)
		else $error("flush ended early");

endmodule

/* sv/bae_dp.sv */
module bae_dp #(
	parameter int unsigned PROB_WIDTH = 12
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  bae_pkg::cmd_t         cmd,
	output bae_pkg::status_t      status,
	input  logic                  bit_value,
	input  logic [PROB_WIDTH:0]   prob_one,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [7:0]            out_byte,
	output logic                  last_of_run
);
	import bae_pkg::*;

	localparam int unsigned PROD_W = BOUND_W + PROB_WIDTH + 1;

	logic [BOUND_W-1:0] low_q;
	logic [BOUND_W-1:0] high_q;
	logic [BOUND_W-1:0] prod_s1;
	logic               bit_q;
	logic               out_valid_q;
	logic [BYTE_W-1:0]  out_byte_q;
	logic               last_q;

	logic [BOUND_W-1:0] span;
	logic [PROD_W-1:0]  prod_full;
	logic [BOUND_W-1:0] split;
	logic [BOUND_W-1:0] upd_low;
	logic [BOUND_W-1:0] upd_high;
	logic [BOUND_W-1:0] upd_diff;
	logic [BOUND_W-1:0] cur_diff;

	// Span times probability, scaled back down by the probability width.
	assign span      = high_q - low_q;
	assign prod_full = PROD_W'(span) * PROD_W'(prob_one);

	// Interval narrowing from the registered product.
	assign split    = low_q + prod_s1;
	assign upd_low  = bit_q ? low_q : (split + BOUND_W'(1));
	assign upd_high = bit_q ? split : high_q;
	assign upd_diff = upd_low ^ upd_high;
	assign cur_diff = low_q ^ high_q;

	assign status.slot_free  = !out_valid_q || out_ready;
	assign status.upd_match  = (upd_diff[BOUND_W-1 -: BYTE_W] == '0);
	assign status.match_next = (cur_diff[BOUND_W-BYTE_W-1 -: BYTE_W] == '0);

	// Bounds registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q  <= BOUND_INIT_LOW;
			high_q <= BOUND_INIT_HIGH;
		end else if (cmd.restore) begin
			low_q  <= BOUND_INIT_LOW;
			high_q <= BOUND_INIT_HIGH;
		end else if (cmd.update) begin
			low_q  <= upd_low;
			high_q <= upd_high;
		end else if (cmd.emit) begin
			low_q  <= {low_q[BOUND_W-BYTE_W-1:0], {BYTE_W{1'b0}}};
			high_q <= {high_q[BOUND_W-BYTE_W-1:0], HIGH_FILL};
		end
	end

	// Product and coded bit, captured when an encode word is accepted.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			prod_s1 <= prod_full[PROB_WIDTH +: BOUND_W];
			bit_q   <= bit_value;
		end
	end

	// Output stage valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output stage payload.
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_byte_q <= low_q[BOUND_W-1 -: BYTE_W];
			last_q     <= cmd.last;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_byte    = out_byte_q;
	assign last_of_run = last_q;

	// A flush leaves the coder at its initial interval.
	a_restore: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.restore |=> (low_q == BOUND_INIT_LOW) && (high_q == BOUND_INIT_HIGH))
		else $error("bounds not restored after flush");

	// A plain shift clears the bottom byte of low.
	a_shift_low: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && !cmd.restore && !cmd.update) |=> (low_q[BYTE_W-1:0] == '0))
		else $error("low bound not shifted");

	// Update and emit never coincide.
	a_cmd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.update && (cmd.emit || cmd.capture)))
		else $error("conflicting datapath commands");

endmodule

/* sv/binary_arith_encoder_core.sv */
// Binary arithmetic encoder with 32-bit low and high bounds.
// Input channel (in_valid/in_ready): one word per coded bit (req_type 0,
// with bit_value and prob_one scaled by 2^PROB_WIDTH) or a flush (req_type 1).
// Output channel (out_valid/out_ready): one compressed byte per word, with
// last_of_run high on the final byte that an input word produces.
// In an encode word the span times probability product is registered at
// acceptance and the interval is narrowed in the next cycle.
// Renormalization then emits up to four bytes, each once the output
// register has room. A flush emits the four bytes of low, most
// significant first; the bounds then return to their initial values.
// The first byte of an encode word is loaded from S_EMIT after S_UPD,
// that of a flush from S_FLUSH; either waits for room in the output register.
// One input word is in work at a time; in_ready is high only when idle.
// A stalled receiver holds the output register, and emission waits.
// Reset clears the bounds to 0 and 0xFFFFFFFF and drops any pending byte.
module binary_arith_encoder_core #(
	parameter int unsigned PROB_WIDTH = 12
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                req_type,
	input  logic                bit_value,
	input  logic [PROB_WIDTH:0] prob_one,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [7:0]          out_byte,
	output logic                last_of_run
);
	import bae_pkg::*;

	cmd_t    cmd;
	status_t status;

	// Sequencer for bound updates and byte emission.
	bae_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.req_type (req_type),
		.status   (status),
		.cmd      (cmd)
	);

	// Bounds, multiplier and output register.
	bae_dp #(
		.PROB_WIDTH (PROB_WIDTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.bit_value   (bit_value),
		.prob_one    (prob_one),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_byte    (out_byte),
		.last_of_run (last_of_run)
	);

endmodule

/* tb/binary_arith_encoder_core_tb.sv */
`timescale 1ns / 1ps

module binary_arith_encoder_core_tb;
	import bae_pkg::*;

	localparam int unsigned PROB_W = 12;
	localparam int unsigned FULL_SCALE = 1 << PROB_W;
	localparam int unsigned PROB_MAX = (1 << (PROB_W + 1)) - 1;
	localparam int unsigned RANDOM_WORDS = 500;
	localparam int unsigned HOLD_OFF_CYCLES = 300;
	localparam int unsigned DRAIN_CYCLES = 16;

	typedef enum logic {
		REQ_ENCODE = 1'b0,
		REQ_FLUSH  = 1'b1
	} req_kind_t;

	// Probability field as driven on the input port.
	typedef logic [PROB_W:0] prob_t;

	// One expected byte of the compressed stream.
	typedef struct packed {
		logic [BYTE_W-1:0] value;
		logic              last;
	} coded_byte_t;

	// Tracks the coder interval and the bytes that are still owed by the block.
	class byte_stream_scoreboard;
		logic [BOUND_W-1:0] low_bound;
		logic [BOUND_W-1:0] high_bound;
		coded_byte_t        owed[$];
		int unsigned        errors;

		function new();
			low_bound = BOUND_INIT_LOW;
			high_bound = BOUND_INIT_HIGH;
			errors = 0;
		endfunction

		task report(string msg);
			$display("ERROR at %0t: %s", $time, msg);
			errors++;
		endtask

		// Works out the bytes that one accepted input word produces.
		function void note_word(req_kind_t kind, logic bit_val, logic [PROB_W:0] prob);
			logic [BOUND_W+PROB_W:0] product;
			logic [BOUND_W-1:0]      span;
			logic [BOUND_W-1:0]      split;
			coded_byte_t             staged[$];
			coded_byte_t             entry;
			if (kind == REQ_FLUSH) begin
				for (int i = 3; i >= 0; i--) begin
					entry.value = low_bound[i*BYTE_W +: BYTE_W];
					entry.last = 1'b0;
					staged.push_back(entry);
				end
				low_bound = BOUND_INIT_LOW;
				high_bound = BOUND_INIT_HIGH;
			end else begin
				// Split the interval; all bound arithmetic wraps at 32 bits.
				span = high_bound - low_bound;
				product = (BOUND_W+PROB_W+1)'(span);
				product = product * (BOUND_W+PROB_W+1)'(prob);
				split = low_bound + product[PROB_W +: BOUND_W];
				if (bit_val)
					high_bound = split;
				else
					low_bound = split + BOUND_W'(1);
				// Shift out top bytes while the bounds agree on them.
				while (low_bound[BOUND_W-1 -: BYTE_W] == high_bound[BOUND_W-1 -: BYTE_W]
						&& staged.size() < 4) begin
					entry.value = low_bound[BOUND_W-1 -: BYTE_W];
					entry.last = 1'b0;
					staged.push_back(entry);
					low_bound = low_bound << BYTE_W;
					high_bound = {high_bound[BOUND_W-BYTE_W-1:0], HIGH_FILL};
				end
			end
			if (staged.size() > 0)
				staged[staged.size()-1].last = 1'b1;
			foreach (staged[i])
				owed.push_back(staged[i]);
		endfunction

		// Compares one received byte with the oldest owed byte.
		task check_byte(logic [BYTE_W-1:0] value, logic last);
			coded_byte_t want;
			if (owed.size() == 0) begin
				report($sformatf("unexpected word %02h last %0b", value, last));
			end else begin
				want = owed.pop_front();
				if (value !== want.value)
					report($sformatf("out_byte got %02h, expected %02h", value, want.value));
				if (last !== want.last)
					report($sformatf("last_of_run got %0b, expected %0b on byte %02h",
						last, want.last, want.value));
			end
		endtask
	endclass

	logic                clk;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic                req_type = 1'b0;
	logic                bit_value = 1'b0;
	logic [PROB_W:0]     prob_one = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [BYTE_W-1:0]   out_byte;
	logic                last_of_run;

	logic                hold_off = 1'b0;
	int unsigned         words_accepted = 0;
	int unsigned         burst_left = 0;
	byte_stream_scoreboard sb;

	binary_arith_encoder_core #(
		.PROB_WIDTH(PROB_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.req_type(req_type),
		.bit_value(bit_value),
		.prob_one(prob_one),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_byte(out_byte),
		.last_of_run(last_of_run)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Offers one input word, with a random gap first when a burst has run out.
	task send_word(req_kind_t kind, logic bit_val, logic [PROB_W:0] prob);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		in_valid <= 1'b1;
		req_type <= kind;
		bit_value <= bit_val;
		prob_one <= prob;
		do
			@(posedge clk);
		while (!in_ready);
		sb.note_word(kind, bit_val, prob);
		words_accepted++;
		burst_left--;
	endtask

	// Random encode word: mostly bits that follow their probability.
	task send_random_encode();
		logic [PROB_W:0] prob;
		logic            bit_val;
		int unsigned     pick;
		pick = $urandom_range(0, 99);
		if (pick < 55)
			prob = prob_t'($urandom_range(0, FULL_SCALE));
		else if (pick < 70)
			prob = prob_t'(($urandom_range(0, 1) != 0) ? $urandom_range(0, 15)
				: $urandom_range(FULL_SCALE - 15, FULL_SCALE));
		else
			prob = prob_t'($urandom_range(0, PROB_MAX));
		if ($urandom_range(0, 3) != 0)
			bit_val = ($urandom_range(0, FULL_SCALE - 1) < prob);
		else
			bit_val = 1'($urandom_range(0, 1));
		send_word(REQ_ENCODE, bit_val, prob);
	endtask

	// Receiver: checks accepted words and stalls on phases of its own pattern.
	initial begin : receiver
		int unsigned      phase_left;
		int unsigned      mode;
		logic [15:0]      ready_pattern;
		phase_left = 0;
		mode = 0;
		ready_pattern = '1;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				sb.check_byte(out_byte, last_of_run);
			if (phase_left == 0) begin
				mode = $urandom_range(0, 3);
				phase_left = $urandom_range(16, 96);
				ready_pattern = 16'($urandom);
			end
			phase_left--;
			ready_pattern = {ready_pattern[14:0], ready_pattern[15]};
			if (hold_off)
				out_ready <= 1'b0;
			else begin
				case (mode)
					0: begin
						out_ready <= 1'b1;
					end
					1: begin
						out_ready <= ($urandom_range(0, 3) != 0);
					end
					2: begin
						out_ready <= 1'($urandom_range(0, 1));
					end
					default: begin
						out_ready <= ready_pattern[0];
					end
				endcase
			end
		end
	end

	// Long receiver hold-off so the block backs up into its input.
	initial begin : pressure
		wait (words_accepted >= 120);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_OFF_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	// Run limit.
	initial begin : watchdog
		#2_000_000;
		$display("binary_arith_encoder_core_tb: errors");
		$finish;
	end

	initial begin : stimulus
		sb = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Flush straight after reset gives four zero bytes.
		send_word(REQ_FLUSH, 1'b0, '0);
		// Zero probability with a one collapses the bounds: four bytes out.
		send_word(REQ_ENCODE, 1'b1, '0);
		// Full scale with a zero wraps low back to the start, no bytes.
		send_word(REQ_ENCODE, 1'b0, prob_t'(FULL_SCALE));
		send_word(REQ_ENCODE, 1'b1, prob_t'(FULL_SCALE));
		send_word(REQ_ENCODE, 1'b0, '0);
		send_word(REQ_ENCODE, 1'b1, prob_t'(1));
		send_word(REQ_ENCODE, 1'b0, prob_t'(FULL_SCALE - 1));
		// Probabilities above full scale push the split past high.
		send_word(REQ_ENCODE, 1'b1, prob_t'(PROB_MAX));
		send_word(REQ_ENCODE, 1'b0, prob_t'(PROB_MAX));
		send_word(REQ_ENCODE, 1'b0, prob_t'(FULL_SCALE + 1));
		send_word(REQ_ENCODE, 1'b1, 13'h1555);
		send_word(REQ_ENCODE, 1'b0, 13'h0AAA);
		// Flush with the ignored fields at their extremes.
		send_word(REQ_FLUSH, 1'b1, prob_t'(PROB_MAX));
		send_word(REQ_ENCODE, 1'b1, prob_t'(FULL_SCALE / 2));
		send_word(REQ_ENCODE, 1'b1, prob_t'(FULL_SCALE / 2));
		send_word(REQ_ENCODE, 1'b0, prob_t'(FULL_SCALE / 2));
		send_word(REQ_ENCODE, 1'b1, prob_t'(16));
		send_word(REQ_ENCODE, 1'b0, prob_t'(4000));
		send_word(REQ_ENCODE, 1'b1, '0);
		send_word(REQ_FLUSH, 1'b0, prob_t'(FULL_SCALE));

		// Random part: encodes with an occasional flush.
		for (int i = 0; i < RANDOM_WORDS; i++) begin
			if ($urandom_range(0, 99) < 6)
				send_word(REQ_FLUSH, 1'($urandom_range(0, 1)),
					prob_t'($urandom_range(0, PROB_MAX)));
			else
				send_random_encode();
		end
		send_word(REQ_FLUSH, 1'b0, '0);
		in_valid <= 1'b0;

		// Drain, then give any stray byte time to show up.
		while (sb.owed.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("binary_arith_encoder_core_tb: clean");
		else
			$display("binary_arith_encoder_core_tb: errors");
		$finish;
	end

endmodule
